[hw/rtl/wmhq_pkg.sv]
// wmhq_pkg: shared constants, request and status codes, and sequencer states
// for the warning max-heap queue. No dependencies.
`timescale 1ns / 1ps
package wmhq_pkg;

    localparam int DEPTH_DEF        = 64;
    localparam int SCENE_BITS_DEF   = 8;
    localparam int LEVEL_BITS_DEF   = 8;
    localparam int PAYLOAD_BITS_DEF = 32;

    localparam int REQ_BITS    = 3;
    localparam int STATUS_BITS = 2;

    typedef logic [REQ_BITS-1:0]    t_req;
    typedef logic [STATUS_BITS-1:0] t_status;

    localparam t_req REQ_INSERT = 3'd0;
    localparam t_req REQ_POP_HI = 3'd1;
    localparam t_req REQ_POP_LO = 3'd2;
    localparam t_req REQ_PEEK   = 3'd3;
    localparam t_req REQ_CLEAR  = 3'd4;

    localparam t_status ST_DONE  = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_EVICT = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PEEK,
        S_RH_ROOT,
        S_RH_LAST,
        S_SD_LEFT,
        S_SD_RIGHT,
        S_SD_CMP,
        S_RL_LAST,
        S_RL_SCAN,
        S_SU_RD,
        S_SU_CMP,
        S_DONE
    } t_state;

endpackage

[hw/rtl/wmhq_if.sv]
// wmhq_if: valid/ready channel interfaces for requests and results of the
// warning max-heap queue. Depends on wmhq_pkg.
`timescale 1ns / 1ps
interface wmhq_req_if #(
    parameter int SCENE_BITS   = wmhq_pkg::SCENE_BITS_DEF,
    parameter int LEVEL_BITS   = wmhq_pkg::LEVEL_BITS_DEF,
    parameter int PAYLOAD_BITS = wmhq_pkg::PAYLOAD_BITS_DEF
);
    logic                    valid;
    logic                    ready;
    wmhq_pkg::t_req          req_type;
    logic [SCENE_BITS-1:0]   scene;
    logic [LEVEL_BITS-1:0]   level;
    logic [PAYLOAD_BITS-1:0] payload;

    modport source (output valid, req_type, scene, level, payload, input ready);
    modport sink   (input valid, req_type, scene, level, payload, output ready);
endinterface

interface wmhq_res_if #(
    parameter int DEPTH        = wmhq_pkg::DEPTH_DEF,
    parameter int SCENE_BITS   = wmhq_pkg::SCENE_BITS_DEF,
    parameter int LEVEL_BITS   = wmhq_pkg::LEVEL_BITS_DEF,
    parameter int PAYLOAD_BITS = wmhq_pkg::PAYLOAD_BITS_DEF
);
    localparam int CW = $clog2(DEPTH + 1);

    logic                    valid;
    logic                    ready;
    wmhq_pkg::t_status       status;
    logic                    item_valid;
    logic [SCENE_BITS-1:0]   out_scene;
    logic [LEVEL_BITS-1:0]   out_level;
    logic [PAYLOAD_BITS-1:0] out_payload;
    logic [CW-1:0]           occupancy;

    modport source (output valid, status, item_valid, out_scene, out_level, out_payload,
                    occupancy, input ready);
    modport sink   (input valid, status, item_valid, out_scene, out_level, out_payload,
                    occupancy, output ready);
endinterface

[hw/rtl/wmhq_ram.sv]
// wmhq_ram: generic simple dual-port RAM, one write and one registered read
// per cycle. No dependencies.
`timescale 1ns / 1ps
module wmhq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[hw/rtl/warning_max_heap_queue.sv]
// warning_max_heap_queue: binary max-heap of warning messages keyed by
// scene + level, held in one wmhq_ram. Depends on wmhq_pkg, wmhq_if, wmhq_ram.
//
//   channel  dir  fields
//   i_req    in   req_type, scene, level, payload
//   o_res    out  status, item_valid, out_scene, out_level, out_payload, occupancy
//
// One request at a time; every RAM step is a read and a compare in the next cycle.
// Peek reads the root; clear, refused and unused requests go straight to the result. Insert: a sift-up.
// Remove highest reads the root and the last entry, then sifts down. Remove lowest and full insert:
// a scan of the leaves for the lowest key, then the sift-up(s).
// Reset clears the sequencer state, the entry count, the flags and the output valid; no clearing pass over the RAM.
// A finished result waits in the output register while the next request is taken.
`timescale 1ns / 1ps
module warning_max_heap_queue #(
    parameter int DEPTH        = wmhq_pkg::DEPTH_DEF,
    parameter int SCENE_BITS   = wmhq_pkg::SCENE_BITS_DEF,
    parameter int LEVEL_BITS   = wmhq_pkg::LEVEL_BITS_DEF,
    parameter int PAYLOAD_BITS = wmhq_pkg::PAYLOAD_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wmhq_req_if.sink   i_req,
    wmhq_res_if.source o_res
);
    import wmhq_pkg::*;

    localparam int EW = SCENE_BITS + LEVEL_BITS + PAYLOAD_BITS;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int KW = ((SCENE_BITS > LEVEL_BITS) ? SCENE_BITS : LEVEL_BITS) + 1;

    // entry layout: {scene, level, payload}
    function automatic logic [KW-1:0] key_of(input logic [EW-1:0] e);
        key_of = KW'(e[EW-1 -: SCENE_BITS]) + KW'(e[PAYLOAD_BITS +: LEVEL_BITS]);
    endfunction

    function automatic logic [AW-1:0] to_addr(input logic [CW-1:0] idx);
        logic [CW-1:0] a;
        a = idx - 1'b1;
        to_addr = a[AW-1:0];
    endfunction

    t_state        r_state,  n_state;
    logic [CW-1:0] r_cnt,    n_cnt;
    logic [CW-1:0] r_idx,    n_idx;
    logic [EW-1:0] r_mov,    n_mov;
    logic [EW-1:0] r_fresh,  n_fresh;
    logic          r_push,   n_push;
    logic [EW-1:0] r_item,   n_item;
    t_status       r_status, n_status;
    logic          r_itemv,  n_itemv;
    logic [EW-1:0] r_pick,   n_pick;
    logic [CW-1:0] r_pidx,   n_pidx;
    logic [CW-1:0] r_scan,   n_scan;
    logic          r_pend,   n_pend;
    logic          r_has_r,  n_has_r;

    logic          r_o_valid,  n_o_valid;
    t_status       r_o_status, n_o_status;
    logic          r_o_itemv,  n_o_itemv;
    logic [EW-1:0] r_o_item,   n_o_item;
    logic [CW-1:0] r_o_occ,    n_o_occ;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [EW-1:0] ram_rdata;

    logic [CW:0]   dbl;
    logic [CW:0]   cnt_x;
    logic [CW-1:0] par;
    logic [CW-1:0] lim;
    logic [CW-1:0] rl_first;
    logic [EW-1:0] in_entry;
    logic          take_r;
    logic [EW-1:0] chosen;
    logic [CW-1:0] chosen_idx;
    logic          su_fin;

    wmhq_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_heap_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign dbl        = {r_idx, 1'b0};
    assign cnt_x      = {1'b0, r_cnt};
    assign par        = r_idx >> 1;
    assign lim        = CW'((r_cnt >> 1) + 1'b1);
    assign rl_first   = CW'(r_cnt - 1'b1);
    assign in_entry   = {i_req.scene, i_req.level, i_req.payload};
    assign take_r     = r_has_r && (key_of(r_pick) < key_of(ram_rdata));
    assign chosen     = take_r ? ram_rdata : r_pick;
    assign chosen_idx = take_r ? CW'(r_pidx + 1'b1) : r_pidx;

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_res.valid       = r_o_valid;
    assign o_res.status      = r_o_status;
    assign o_res.item_valid  = r_o_itemv;
    assign o_res.out_scene   = r_o_item[EW-1 -: SCENE_BITS];
    assign o_res.out_level   = r_o_item[PAYLOAD_BITS +: LEVEL_BITS];
    assign o_res.out_payload = r_o_item[PAYLOAD_BITS-1:0];
    assign o_res.occupancy   = r_o_occ;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_idx      = r_idx;
        n_mov      = r_mov;
        n_fresh    = r_fresh;
        n_push     = r_push;
        n_item     = r_item;
        n_status   = r_status;
        n_itemv    = r_itemv;
        n_pick     = r_pick;
        n_pidx     = r_pidx;
        n_scan     = r_scan;
        n_pend     = r_pend;
        n_has_r    = r_has_r;
        n_o_valid  = r_o_valid;
        n_o_status = r_o_status;
        n_o_itemv  = r_o_itemv;
        n_o_item   = r_o_item;
        n_o_occ    = r_o_occ;
        ram_we     = 1'b0;
        ram_waddr  = to_addr(r_idx);
        ram_wdata  = r_mov;
        ram_raddr  = '0;
        su_fin     = 1'b0;

        if (o_res.ready) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_status = ST_DONE;
                    n_itemv  = 1'b0;
                    n_push   = 1'b0;
                    n_state  = S_DONE;
                    unique case (i_req.req_type)
                        REQ_INSERT: begin
                            n_fresh = in_entry;
                            if (r_cnt >= CW'(DEPTH)) begin
                                n_status  = ST_EVICT;
                                n_push    = 1'b1;
                                ram_raddr = to_addr(r_cnt);
                                n_state   = S_RL_LAST;
                            end else begin
                                n_mov   = in_entry;
                                n_cnt   = CW'(r_cnt + 1'b1);
                                n_idx   = CW'(r_cnt + 1'b1);
                                n_state = S_SU_RD;
                            end
                        end
                        REQ_POP_HI, REQ_POP_LO, REQ_PEEK: begin
                            if (r_cnt == '0) begin
                                n_status = ST_EMPTY;
                            end else if (i_req.req_type == REQ_POP_LO) begin
                                ram_raddr = to_addr(r_cnt);
                                n_state   = S_RL_LAST;
                            end else if (i_req.req_type == REQ_POP_HI) begin
                                n_state = S_RH_ROOT;
                            end else begin
                                n_state = S_PEEK;
                            end
                        end
                        REQ_CLEAR: begin
                            n_cnt = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_PEEK: begin
                n_item  = ram_rdata;
                n_itemv = 1'b1;
                n_state = S_DONE;
            end
            S_RH_ROOT: begin
                n_item    = ram_rdata;
                n_itemv   = 1'b1;
                ram_raddr = to_addr(r_cnt);
                n_state   = S_RH_LAST;
            end
            S_RH_LAST: begin
                n_mov   = ram_rdata;
                n_cnt   = CW'(r_cnt - 1'b1);
                n_idx   = CW'(1);
                n_state = S_SD_LEFT;
            end
            S_SD_LEFT: begin
                if (dbl > cnt_x) begin
                    ram_we  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    ram_raddr = to_addr(dbl[CW-1:0]);
                    n_state   = S_SD_RIGHT;
                end
            end
            S_SD_RIGHT: begin
                n_pick  = ram_rdata;
                n_pidx  = dbl[CW-1:0];
                n_has_r = (dbl != cnt_x);
                ram_raddr = dbl[AW-1:0];
                n_state = S_SD_CMP;
            end
            S_SD_CMP: begin
                ram_we = 1'b1;
                if (key_of(chosen) > key_of(r_mov)) begin
                    ram_wdata = chosen;
                    n_idx     = chosen_idx;
                    n_state   = S_SD_LEFT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_RL_LAST: begin
                n_mov  = ram_rdata;
                n_pick = ram_rdata;
                n_pidx = r_cnt;
                if (rl_first >= lim) begin
                    ram_raddr = to_addr(rl_first);
                    n_scan    = CW'(rl_first - 1'b1);
                    n_pend    = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                n_state = S_RL_SCAN;
            end
            S_RL_SCAN: begin
                if (r_pend) begin
                    // strict compare: on ties the higher index stays
                    if (key_of(ram_rdata) < key_of(r_pick)) begin
                        n_pick = ram_rdata;
                        n_pidx = CW'(r_scan + 1'b1);
                    end
                    if (r_scan >= lim) begin
                        ram_raddr = to_addr(r_scan);
                        n_scan    = CW'(r_scan - 1'b1);
                    end else begin
                        n_pend = 1'b0;
                    end
                end else begin
                    n_item  = r_pick;
                    n_itemv = 1'b1;
                    n_idx   = r_pidx;
                    n_cnt   = CW'(r_cnt - 1'b1);
                    n_state = S_SU_RD;
                end
            end
            S_SU_RD: begin
                if (par == '0) begin
                    ram_we = 1'b1;
                    su_fin = 1'b1;
                end else begin
                    ram_raddr = to_addr(par);
                    n_state   = S_SU_CMP;
                end
            end
            S_SU_CMP: begin
                ram_we = 1'b1;
                if (key_of(ram_rdata) < key_of(r_mov)) begin
                    ram_wdata = ram_rdata;
                    n_idx     = par;
                    n_state   = S_SU_RD;
                end else begin
                    su_fin = 1'b1;
                end
            end
            S_DONE: begin
                if (!r_o_valid || o_res.ready) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_status;
                    n_o_itemv  = r_itemv;
                    n_o_item   = r_itemv ? r_item : '0;
                    n_o_occ    = r_cnt;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // sift-up finished: a full-heap insert now places the new entry
        if (su_fin) begin
            if (r_push) begin
                n_push  = 1'b0;
                n_mov   = r_fresh;
                n_cnt   = CW'(r_cnt + 1'b1);
                n_idx   = CW'(r_cnt + 1'b1);
                n_state = S_SU_RD;
            end else begin
                n_state = S_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_push    <= 1'b0;
            r_pend    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_push    <= n_push;
            r_pend    <= n_pend;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_mov      <= n_mov;
        r_fresh    <= n_fresh;
        r_item     <= n_item;
        r_status   <= n_status;
        r_itemv    <= n_itemv;
        r_pick     <= n_pick;
        r_pidx     <= n_pidx;
        r_scan     <= n_scan;
        r_has_r    <= n_has_r;
        r_o_status <= n_o_status;
        r_o_itemv  <= n_o_itemv;
        r_o_item   <= n_o_item;
        r_o_occ    <= n_o_occ;
    end

`ifndef NO_ASSERTIONS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("entry count above depth");

    a_we_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_SU_RD || r_state == S_SU_CMP ||
                    r_state == S_SD_LEFT || r_state == S_SD_CMP))
        else $error("heap write outside a sift step");

    a_evict_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.status == ST_EVICT) |->
            (o_res.item_valid && o_res.occupancy == CW'(DEPTH)))
        else $error("eviction without item or with heap not full");

    a_empty_refuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.status == ST_EMPTY) |->
            (!o_res.item_valid && o_res.occupancy == '0))
        else $error("empty refusal with item or nonzero occupancy");
`endif
endmodule
